// ----- rtl/aaw_pkg.sv -----
// Package for the asymmetric analysis window: sizes, register codes and window ROM contents.
package aaw_pkg;

  localparam int unsigned RISE_ANALYSIS_10MS = 64;
  localparam int unsigned RISE_ANALYSIS_20MS = 128;
  localparam int unsigned RISE_PERCEPT_10MS  = 64;
  localparam int unsigned RISE_PERCEPT_20MS  = 128;
  localparam int unsigned TAIL_SHORT         = 32;
  localparam int unsigned TAIL_LONG          = 64;

  // The short tail never runs past the long tail region.
  localparam int unsigned SHORT_LEN = (TAIL_SHORT > TAIL_LONG) ? TAIL_LONG : TAIL_SHORT;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned ONE_Q15  = 32768;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    CFG_FRAME_LEN  = 2'd0,
    CFG_LPC_WINDOW = 2'd1,
    CFG_TEN_MS     = 2'd2,
    CFG_LONG_TAIL  = 2'd3
  } cfg_reg_t;

  // Window ROM layout: four rise tables, long tail, short tail, unity, zero.
  localparam int unsigned BASE_A10   = 0;
  localparam int unsigned BASE_A20   = BASE_A10 + RISE_ANALYSIS_10MS;
  localparam int unsigned BASE_P10   = BASE_A20 + RISE_ANALYSIS_20MS;
  localparam int unsigned BASE_P20   = BASE_P10 + RISE_PERCEPT_10MS;
  localparam int unsigned BASE_LONG  = BASE_P20 + RISE_PERCEPT_20MS;
  localparam int unsigned BASE_SHORT = BASE_LONG + TAIL_LONG;
  localparam int unsigned ADDR_ONE   = BASE_SHORT + SHORT_LEN;
  localparam int unsigned ADDR_ZERO  = ADDR_ONE + 1;
  localparam int unsigned ROM_DEPTH  = ADDR_ZERO + 1;
  localparam int unsigned ROM_AW     = $clog2(ROM_DEPTH);

  localparam int unsigned DEN_A10   = RISE_ANALYSIS_10MS + 1;
  localparam int unsigned DEN_A20   = RISE_ANALYSIS_20MS + 1;
  localparam int unsigned DEN_P10   = RISE_PERCEPT_10MS + 1;
  localparam int unsigned DEN_P20   = RISE_PERCEPT_20MS + 1;
  localparam int unsigned DEN_LONG  = TAIL_LONG + 1;
  localparam int unsigned DEN_SHORT = SHORT_LEN + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t coef_rom_t [ROM_DEPTH];

  // Sine of a Q30 angle by its Taylor series up to the eleventh power, rounded to Q15.
  function automatic coef_t sine_q15(input logic [63:0] ang);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] sum;
    a2   = (ang * ang) >> 30;
    term = ang;
    sum  = ang;
    term = ((term * a2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * a2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * a2) >> 30) / 64'd110;
    sum  = sum - term;
    sum  = (sum + 64'd16384) >> 15;
    if (sum > 64'(ONE_Q15)) begin
      sum = 64'(ONE_Q15);
    end
    return COEF_W'(sum);
  endfunction

  // Fills the window ROM at elaboration.
  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    logic [63:0] n;
    for (int unsigned i = 0; i < RISE_ANALYSIS_10MS; i++) begin
      n = 64'(i + 1);
      rom[BASE_A10 + i] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_A10 / 2)) / DEN_A10);
    end
    for (int unsigned i = 0; i < RISE_ANALYSIS_20MS; i++) begin
      n = 64'(i + 1);
      rom[BASE_A20 + i] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_A20 / 2)) / DEN_A20);
    end
    for (int unsigned i = 0; i < RISE_PERCEPT_10MS; i++) begin
      n = 64'(i + 1);
      rom[BASE_P10 + i] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_P10 / 2)) / DEN_P10);
    end
    for (int unsigned i = 0; i < RISE_PERCEPT_20MS; i++) begin
      n = 64'(i + 1);
      rom[BASE_P20 + i] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_P20 / 2)) / DEN_P20);
    end
    for (int unsigned j = 0; j < TAIL_LONG; j++) begin
      n = 64'(TAIL_LONG - j);
      rom[BASE_LONG + j] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_LONG / 2)) / DEN_LONG);
    end
    for (int unsigned j = 0; j < SHORT_LEN; j++) begin
      n = 64'(SHORT_LEN - j);
      rom[BASE_SHORT + j] = sine_q15((n * HALF_PI_Q30 + 64'(DEN_SHORT / 2)) / DEN_SHORT);
    end
    rom[ADDR_ONE]  = COEF_W'(ONE_Q15);
    rom[ADDR_ZERO] = '0;
    return rom;
  endfunction

  localparam coef_rom_t WIN_ROM = build_rom();

endpackage

// ----- rtl/asymmetric_analysis_window.sv -----
// Top level of the asymmetric analysis window: frame position, window ROM and multiplier.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_sample_in (Q1.15)
//   out_     output     out_valid / out_stall out_windowed_sample, out_frame_end
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One sample is taken per cycle unless the pipeline is held by an output stall.
// The ROM address is registered at the transfer, then the window ROM read, the multiply
// and the rounding are each registered in turn.
// Reset (synchronous, active low) restores the default registers and starts a new frame.
// When the result register is full and stalled, the whole pipeline holds and the
// input side is stalled in the same cycle; otherwise a new transfer is taken every cycle.
module asymmetric_analysis_window (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [aaw_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [aaw_pkg::SAMPLE_W-1:0] out_windowed_sample,
  output logic                                out_frame_end,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [aaw_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int unsigned PROD_W = aaw_pkg::SAMPLE_W + aaw_pkg::COEF_W + 1;
  localparam int unsigned RND_W  = PROD_W + 1;

  // Configuration registers.
  logic [aaw_pkg::IDX_W-1:0] frame_len_r;
  logic                      lpc_window_r;
  logic                      ten_ms_r;
  logic                      long_tail_r;

  // Position of the next sample within the frame.
  logic [aaw_pkg::IDX_W-1:0] sample_index_r;
  logic [aaw_pkg::IDX_W-1:0] sample_index_nxt;

  // Pipeline valid flags.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic advance;
  logic in_xfer;

  // Stage payloads.
  logic [aaw_pkg::ROM_AW-1:0]          addr_r;
  logic [aaw_pkg::ROM_AW-1:0]          addr_nxt;
  logic signed [aaw_pkg::SAMPLE_W-1:0] sample1_r, sample2_r;
  logic                                last1_r, last2_r, last3_r;
  aaw_pkg::coef_t                      coef_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic signed [aaw_pkg::SAMPLE_W-1:0] result_r;
  logic                                frame_end_r;

  // Address select.
  logic [aaw_pkg::LEN_W-1:0]  rise_len;
  logic [aaw_pkg::ROM_AW-1:0] rise_base;
  logic [aaw_pkg::LEN_W-1:0]  min_len;
  logic [aaw_pkg::LEN_W-1:0]  eff_len;
  logic [aaw_pkg::LEN_W-1:0]  tail_start;
  logic [aaw_pkg::LEN_W-1:0]  idx_ext;
  logic [aaw_pkg::LEN_W-1:0]  idx_eff;
  logic [aaw_pkg::LEN_W-1:0]  tail_pos;
  logic                       is_last;

  // Rounding.
  logic signed [RND_W-1:0] rounded;
  logic signed [RND_W-1:0] shifted;
  logic signed [aaw_pkg::SAMPLE_W-1:0] result_nxt;

  // The pipeline moves whenever the result register can take a new value.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign in_xfer  = in_valid && advance;

  always_comb begin
    unique case ({lpc_window_r, ten_ms_r})
      2'b11: begin
        rise_len  = aaw_pkg::LEN_W'(aaw_pkg::RISE_ANALYSIS_10MS);
        rise_base = aaw_pkg::ROM_AW'(aaw_pkg::BASE_A10);
      end
      2'b10: begin
        rise_len  = aaw_pkg::LEN_W'(aaw_pkg::RISE_ANALYSIS_20MS);
        rise_base = aaw_pkg::ROM_AW'(aaw_pkg::BASE_A20);
      end
      2'b01: begin
        rise_len  = aaw_pkg::LEN_W'(aaw_pkg::RISE_PERCEPT_10MS);
        rise_base = aaw_pkg::ROM_AW'(aaw_pkg::BASE_P10);
      end
      default: begin
        rise_len  = aaw_pkg::LEN_W'(aaw_pkg::RISE_PERCEPT_20MS);
        rise_base = aaw_pkg::ROM_AW'(aaw_pkg::BASE_P20);
      end
    endcase
  end

  always_comb begin
    // Frames shorter than rise plus long tail are stretched to that length.
    min_len    = rise_len + aaw_pkg::LEN_W'(aaw_pkg::TAIL_LONG);
    eff_len    = ({1'b0, frame_len_r} < min_len) ? min_len : {1'b0, frame_len_r};
    tail_start = eff_len - aaw_pkg::LEN_W'(aaw_pkg::TAIL_LONG);
    idx_ext    = {1'b0, sample_index_r};
    // An index at or past the final position (frame_len lowered mid-frame)
    // is handled as the final sample.
    is_last    = idx_ext >= (eff_len - 1'b1);
    idx_eff    = is_last ? (eff_len - 1'b1) : idx_ext;
    tail_pos   = idx_eff - tail_start;

    if (idx_eff < rise_len) begin
      addr_nxt = rise_base + aaw_pkg::ROM_AW'(idx_eff);
    end else if (idx_eff < tail_start) begin
      addr_nxt = aaw_pkg::ROM_AW'(aaw_pkg::ADDR_ONE);
    end else if (long_tail_r) begin
      addr_nxt = aaw_pkg::ROM_AW'(aaw_pkg::BASE_LONG) + aaw_pkg::ROM_AW'(tail_pos);
    end else if (tail_pos < aaw_pkg::LEN_W'(aaw_pkg::SHORT_LEN)) begin
      addr_nxt = aaw_pkg::ROM_AW'(aaw_pkg::BASE_SHORT) + aaw_pkg::ROM_AW'(tail_pos);
    end else begin
      addr_nxt = aaw_pkg::ROM_AW'(aaw_pkg::ADDR_ZERO);
    end

    sample_index_nxt = is_last ? '0 : (aaw_pkg::IDX_W'(idx_eff) + 1'b1);
  end

  // Round half up by adding one half LSB, then floor with an arithmetic shift.
  always_comb begin
    rounded = RND_W'(prod_r) + RND_W'(16384);
    shifted = rounded >>> 15;
    if (shifted > RND_W'(32767)) begin
      result_nxt = 16'sh7FFF;
    end else if (shifted < -RND_W'(32768)) begin
      result_nxt = 16'sh8000;
    end else begin
      result_nxt = aaw_pkg::SAMPLE_W'(shifted);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r    <= aaw_pkg::IDX_W'(320);
      lpc_window_r   <= 1'b1;
      ten_ms_r       <= 1'b0;
      long_tail_r    <= 1'b1;
      sample_index_r <= '0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      v3_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (aaw_pkg::cfg_reg_t'(cfg_index))
          aaw_pkg::CFG_FRAME_LEN:  frame_len_r  <= cfg_wdata;
          aaw_pkg::CFG_LPC_WINDOW: lpc_window_r <= cfg_wdata[0];
          aaw_pkg::CFG_TEN_MS:     ten_ms_r     <= cfg_wdata[0];
          aaw_pkg::CFG_LONG_TAIL:  long_tail_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        sample_index_r <= sample_index_nxt;
      end
      if (advance) begin
        v1_r        <= in_valid;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  // Data path; the window ROM read is registered like a synchronous memory.
  always_ff @(posedge clk) begin
    if (advance) begin
      addr_r      <= addr_nxt;
      sample1_r   <= in_sample_in;
      last1_r     <= is_last;
      coef_r      <= aaw_pkg::WIN_ROM[addr_r];
      sample2_r   <= sample1_r;
      last2_r     <= last1_r;
      prod_r      <= PROD_W'(sample2_r) * PROD_W'($signed({1'b0, coef_r}));
      last3_r     <= last2_r;
      result_r    <= result_nxt;
      frame_end_r <= last3_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_windowed_sample = result_r;
  assign out_frame_end       = frame_end_r;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the asymmetric analysis window: random stimulus, window predictor.
`timescale 1ns / 1ps

// One windowed sample as it leaves the block.
typedef struct packed {
  logic signed [15:0] windowed;
  logic               frame_end;
} window_result_t;

// Keeps its own copy of the window registers and the frame position, predicts the windowed
// sample for every accepted input transfer and checks each output transfer in order.
class window_scoreboard;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned     UNITY       = 32768;
  localparam int unsigned     MAX_PRINTED = 40;

  window_result_t expected_windowed[$];
  int unsigned    frame_len_reg;
  bit             lpc_reg;
  bit             ten_ms_reg;
  bit             long_tail_reg;
  int unsigned    frame_pos;
  int unsigned    mismatches;

  function new();
    frame_len_reg = 320;
    lpc_reg       = 1'b1;
    ten_ms_reg    = 1'b0;
    long_tail_reg = 1'b1;
    frame_pos     = 0;
    mismatches    = 0;
  endfunction

  function void set_window(int unsigned len, bit lpc, bit ten, bit tail);
    frame_len_reg = len & 32'h3FF;
    lpc_reg       = lpc;
    ten_ms_reg    = ten;
    long_tail_reg = tail;
  endfunction

  // Rise length in samples for the current window set and frame duration.
  function int unsigned rise_samples();
    if (lpc_reg) begin
      return ten_ms_reg ? aaw_pkg::RISE_ANALYSIS_10MS : aaw_pkg::RISE_ANALYSIS_20MS;
    end
    return ten_ms_reg ? aaw_pkg::RISE_PERCEPT_10MS : aaw_pkg::RISE_PERCEPT_20MS;
  endfunction

  // Quarter-wave sine of pi/2 * num/den in unsigned Q1.15, from a fixed-point Taylor series in Q30.
  function int unsigned quarter_wave(int unsigned num, int unsigned den);
    longint unsigned ang;
    longint unsigned sq;
    longint unsigned term;
    longint unsigned acc;
    int unsigned     k;
    ang  = (longint'(num) * HALF_PI_Q30 + longint'(den / 2)) / longint'(den);
    sq   = (ang * ang) >> 30;
    term = ang;
    acc  = ang;
    for (k = 1; k <= 5; k++) begin
      term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + 64'd16384) >> 15;
    return (acc > UNITY) ? UNITY : int'(acc);
  endfunction

  // Windows one sample at the current frame position and moves the position on.
  function window_result_t apply_window(logic signed [15:0] sample);
    window_result_t res;
    int unsigned    rise;
    int unsigned    len;
    int unsigned    short_len;
    int unsigned    tail_start;
    int unsigned    pos;
    int unsigned    coef;
    int unsigned    j;
    longint         prod;
    bit             last;
    rise      = rise_samples();
    len       = frame_len_reg;
    short_len = (aaw_pkg::TAIL_SHORT > aaw_pkg::TAIL_LONG) ? aaw_pkg::TAIL_LONG
                                                           : aaw_pkg::TAIL_SHORT;
    // Frames shorter than the rise plus the long tail are stretched to fit both.
    if (len < rise + aaw_pkg::TAIL_LONG) begin
      len = rise + aaw_pkg::TAIL_LONG;
    end
    tail_start = len - aaw_pkg::TAIL_LONG;
    // A position at or past the end (after the frame was shortened) closes the frame.
    pos  = frame_pos;
    last = (pos >= len - 1);
    if (last) begin
      pos = len - 1;
    end
    if (pos < rise) begin
      coef = quarter_wave(pos + 1, rise + 1);
    end else if (pos < tail_start) begin
      coef = UNITY;
    end else begin
      j = pos - tail_start;
      if (long_tail_reg) begin
        coef = quarter_wave(aaw_pkg::TAIL_LONG - j, aaw_pkg::TAIL_LONG + 1);
      end else if (j < short_len) begin
        coef = quarter_wave(short_len - j, short_len + 1);
      end else begin
        coef = 0;
      end
    end
    // Round to nearest with a floor shift, then saturate to Q1.15.
    prod = longint'(sample) * longint'(coef) + 64'sd16384;
    prod = prod >>> 15;
    if (prod > 32767) begin
      prod = 32767;
    end
    if (prod < -32768) begin
      prod = -32768;
    end
    res.windowed  = 16'(prod);
    res.frame_end = last;
    frame_pos     = last ? 0 : ((pos + 1) & 32'h3FF);
    return res;
  endfunction

  function void note_sample(logic signed [15:0] sample);
    expected_windowed.push_back(apply_window(sample));
  endfunction

  function int unsigned pending();
    return expected_windowed.size();
  endfunction

  task report(string what);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t MISMATCH %s", $realtime, what);
    end
    mismatches++;
  endtask

  task check_result(logic signed [15:0] windowed, logic frame_end);
    window_result_t want;
    if (expected_windowed.size() == 0) begin
      report($sformatf("unexpected output transfer windowed=%0d frame_end=%0b",
                       windowed, frame_end));
    end else begin
      want = expected_windowed.pop_front();
      if (windowed !== want.windowed) begin
        report($sformatf("windowed_sample got %0d want %0d", windowed, want.windowed));
      end
      if (frame_end !== want.frame_end) begin
        report($sformatf("frame_end got %0b want %0b", frame_end, want.frame_end));
      end
    end
  endtask
endclass

module tb_top;

  localparam int unsigned SAMPLE_TARGET = 1750;
  // Pipeline depth plus margin, waited out before a register write and at the end.
  localparam int unsigned PIPE_SLACK    = 8;
  localparam int unsigned HOLD_OFF      = 150;
  localparam longint      TIMEOUT_NS    = 64'd12_000_000;

  logic                                clk;
  logic                                rst_n        = 1'b0;
  logic                                in_valid     = 1'b0;
  logic                                in_stall;
  logic signed [aaw_pkg::SAMPLE_W-1:0] in_sample_in = '0;
  logic                                out_valid;
  logic                                out_stall    = 1'b0;
  logic signed [aaw_pkg::SAMPLE_W-1:0] out_windowed_sample;
  logic                                out_frame_end;
  logic                                cfg_we       = 1'b0;
  logic [1:0]                          cfg_index    = aaw_pkg::CFG_FRAME_LEN;
  logic [aaw_pkg::CFG_W-1:0]           cfg_wdata    = '0;

  window_scoreboard sb = new();

  // Flags that shape the traffic: quiet sides never idle, a hold-off request makes the
  // receiver stall for a long stretch so the pipeline backs up into the input.
  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned samples_sent = 0;

  asymmetric_analysis_window dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_windowed_sample (out_windowed_sample),
    .out_frame_end       (out_frame_end),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Random sample, biased now and then toward the ends of the Q1.15 range.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one sample and holds it until the block takes the transfer. It then either
  // returns with in_valid still high so the next sample follows at once, or idles.
  task automatic send_sample(logic signed [15:0] sample);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_sample_in <= sample;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_sample(sample);
    samples_sent++;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges; only called with the block idle.
  task automatic program_window(logic [aaw_pkg::CFG_W-1:0] len, bit lpc, bit ten, bit tail);
    cfg_we    <= 1'b1;
    cfg_index <= aaw_pkg::CFG_FRAME_LEN;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_index <= aaw_pkg::CFG_LPC_WINDOW;
    cfg_wdata <= aaw_pkg::CFG_W'(lpc);
    @(posedge clk);
    cfg_index <= aaw_pkg::CFG_TEN_MS;
    cfg_wdata <= aaw_pkg::CFG_W'(ten);
    @(posedge clk);
    cfg_index <= aaw_pkg::CFG_LONG_TAIL;
    cfg_wdata <= aaw_pkg::CFG_W'(tail);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_window(len, lpc, ten, tail);
  endtask

  task automatic run_phase(logic [aaw_pkg::CFG_W-1:0] len, bit lpc, bit ten, bit tail,
                           int unsigned count);
    program_window(len, lpc, ten, tail);
    repeat (count) send_sample(pick_sample());
    wait_idle();
  endtask

  // Receiver: random stalls, quiet stretches, and a long hold-off on request.
  initial begin
    int unsigned n;
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        n = rx_quiet ? 0 : idle_len();
        out_stall <= (n > 0);
        repeat ((n > 0) ? n : $urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_windowed_sample, out_frame_end);
    end
  end

  initial begin
    logic signed [15:0]        edge_samples [12];
    int unsigned               rise;
    int unsigned               choice;
    logic [aaw_pkg::CFG_W-1:0] len;
    bit                        lpc;
    bit                        ten;
    bit                        tail;
    edge_samples = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555,
                     16'shAAAA, 16'sh4000, 16'shC000, 16'sh7FFF, 16'sh8000, 16'sh3039};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: sample extremes and alternating bit patterns in the reset configuration,
    // back to back through the start of the rise.
    tx_quiet = 1'b1;
    foreach (edge_samples[i]) begin
      send_sample(edge_samples[i]);
    end
    wait_idle();

    // Longest frame, no idling anywhere; ends well past the rise.
    rx_quiet = 1'b1;
    run_phase(10'd1023, 1'b1, 1'b1, 1'b1, 300);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;

    // Frame length zero is stretched to rise plus long tail. The position left by the
    // previous phase lies past the new end, so the first sample closes the frame.
    run_phase(10'd0, 1'b0, 1'b0, 1'b0, 200);

    // Receiver holds off while the sender keeps offering, so the input backs up.
    hold_off_req = 1'b1;
    run_phase(10'd191, 1'b1, 1'b0, 1'b1, 160);

    // Just above the stretch threshold, perceptual 10 ms rise, short tail.
    run_phase(10'd129, 1'b0, 1'b1, 1'b0, 140);

    // Random configurations until the sample budget is spent.
    while (samples_sent < SAMPLE_TARGET) begin
      lpc    = $urandom_range(0, 1);
      ten    = $urandom_range(0, 1);
      tail   = $urandom_range(0, 1);
      rise   = lpc ? (ten ? aaw_pkg::RISE_ANALYSIS_10MS : aaw_pkg::RISE_ANALYSIS_20MS)
                   : (ten ? aaw_pkg::RISE_PERCEPT_10MS : aaw_pkg::RISE_PERCEPT_20MS);
      choice = $urandom_range(0, 19);
      if (choice < 2) begin
        len = '0;
      end else if (choice < 4) begin
        len = '1;
      end else if (choice < 8) begin
        // Right around the point where the frame stops being stretched.
        len = aaw_pkg::CFG_W'(rise + aaw_pkg::TAIL_LONG + $urandom_range(0, 2) - 1);
      end else begin
        len = aaw_pkg::CFG_W'($urandom_range(0, 400));
      end
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      run_phase(len, lpc, ten, tail, $urandom_range(30, 220));
    end

    wait_idle();
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.mismatches == 0) begin
      $display("[asymmetric_analysis_window] OK");
    end else begin
      $display("[asymmetric_analysis_window] ERROR");
    end
    $finish;
  end

  // Hard limit well beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("[asymmetric_analysis_window] ERROR");
    $finish;
  end
endmodule
